/* hw/rtl/eira_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eira_pkg: shared types and constants of the entity ID range allocator
// Request kinds, sequencer states, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package eira_pkg;

    localparam int FREE_SLOTS_DEF = 16;
    localparam int ID_BITS_DEF    = 32;
    localparam int COUNT_BITS     = 16;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        KIND_ALLOC_ONE   = 2'd0,
        KIND_ALLOC_RANGE = 2'd1,
        KIND_REL_ONE     = 2'd2,
        KIND_REL_RANGE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/eira_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eira_ram: free range store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module eira_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/eira_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eira_core: allocation sequencer
// Holds the mark and list count, scans the free list through the range
// store, updates the hit entry or appends one, and closes gaps left by removed ranges.
// ----------------------------------------------------------------------------
module eira_core #(
    parameter int FREE_SLOTS = 16,
    parameter int ID_BITS    = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request
    input  logic                          in_valid,
    output logic                          in_ready,
    input  eira_pkg::kind_t               in_kind,
    input  logic [ID_BITS-1:0]            in_first_id,
    input  logic [ID_BITS-1:0]            in_end_id,
    input  logic [eira_pkg::COUNT_BITS-1:0] in_count,
    // result
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [ID_BITS-1:0]            res_first,
    output logic [ID_BITS-1:0]            res_end,
    output logic                          res_status,
    // range store, entry = {begin, end}
    output logic                          ram_we,
    output logic [$clog2(FREE_SLOTS)-1:0] ram_waddr,
    output logic [2*ID_BITS-1:0]          ram_wdata,
    output logic [$clog2(FREE_SLOTS)-1:0] ram_raddr,
    input  logic [2*ID_BITS-1:0]          ram_rdata
);

    import eira_pkg::*;

    localparam int IDX_W = $clog2(FREE_SLOTS);
    localparam int CNT_W = $clog2(FREE_SLOTS + 1);

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [ID_BITS-1:0] rb_reg, rb_next;
    logic [ID_BITS-1:0] re_reg, re_next;
    logic [ID_BITS-1:0] cnt_reg, cnt_next;
    logic [ID_BITS-1:0] hw_reg, hw_next;
    logic [CNT_W-1:0]   fcnt_reg, fcnt_next;
    logic [ID_BITS-1:0] mk_first_reg, mk_first_next;
    logic [ID_BITS-1:0] mk_end_reg, mk_end_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    logic [CNT_W-1:0]   sh_rd_reg, sh_rd_next;
    logic [IDX_W-1:0]   sh_wr_reg, sh_wr_next;
    logic               sh_vld_reg, sh_vld_next;
    logic [ID_BITS-1:0] res_first_reg, res_first_next;
    logic [ID_BITS-1:0] res_end_reg, res_end_next;
    logic               res_status_reg, res_status_next;

    logic [ID_BITS-1:0] rd_b, rd_e, rd_len, nb;
    logic [ID_BITS-1:0] hw_plus_cnt, mk_first_c, mk_end_c;
    logic               is_alloc, alloc_hit, end_hit, beg_hit;
    logic               last_ev, list_full, scan_issue, sh_issue;
    logic               leave_scan;

    assign rd_b        = ram_rdata[2*ID_BITS-1:ID_BITS];
    assign rd_e        = ram_rdata[ID_BITS-1:0];
    assign rd_len      = rd_e - rd_b;
    assign nb          = rd_b + cnt_reg;
    assign hw_plus_cnt = hw_reg + cnt_reg;
    assign mk_first_c  = hw_reg + ID_BITS'(1);
    assign mk_end_c    = hw_plus_cnt + ID_BITS'(1);

    assign is_alloc   = (kind_reg == KIND_ALLOC_ONE) || (kind_reg == KIND_ALLOC_RANGE);
    // allocate-one takes the front range whatever its length
    assign alloc_hit  = (kind_reg == KIND_ALLOC_ONE) || (rd_len >= cnt_reg);
    assign end_hit    = (rd_e == rb_reg);
    assign beg_hit    = (rd_b == re_reg);
    assign last_ev    = ((CNT_W'(ev_idx_reg) + CNT_W'(1)) == fcnt_reg);
    assign list_full  = (fcnt_reg == CNT_W'(FREE_SLOTS));
    assign scan_issue = (scan_reg < fcnt_reg);
    assign sh_issue   = (sh_rd_reg < fcnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            hw_reg     <= '0;
            fcnt_reg   <= '0;
            ev_vld_reg <= 1'b0;
            sh_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            hw_reg     <= hw_next;
            fcnt_reg   <= fcnt_next;
            ev_vld_reg <= ev_vld_next;
            sh_vld_reg <= sh_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        rb_reg         <= rb_next;
        re_reg         <= re_next;
        cnt_reg        <= cnt_next;
        mk_first_reg   <= mk_first_next;
        mk_end_reg     <= mk_end_next;
        scan_reg       <= scan_next;
        ev_idx_reg     <= ev_idx_next;
        sh_rd_reg      <= sh_rd_next;
        sh_wr_reg      <= sh_wr_next;
        res_first_reg  <= res_first_next;
        res_end_reg    <= res_end_next;
        res_status_reg <= res_status_next;
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        rb_next         = rb_reg;
        re_next         = re_reg;
        cnt_next        = cnt_reg;
        hw_next         = hw_reg;
        fcnt_next       = fcnt_reg;
        mk_first_next   = mk_first_reg;
        mk_end_next     = mk_end_reg;
        scan_next       = scan_reg;
        ev_vld_next     = 1'b0;
        ev_idx_next     = ev_idx_reg;
        sh_rd_next      = sh_rd_reg;
        sh_wr_next      = sh_wr_reg;
        sh_vld_next     = 1'b0;
        res_first_next  = res_first_reg;
        res_end_next    = res_end_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = ev_idx_reg;
        ram_wdata       = {rd_b, rd_e};
        ram_raddr       = '0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        leave_scan      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    kind_next  = in_kind;
                    rb_next    = in_first_id;
                    re_next    = (in_kind == KIND_REL_ONE) ? in_first_id + ID_BITS'(1)
                                                           : in_end_id;
                    cnt_next   = (in_kind == KIND_ALLOC_ONE) ? ID_BITS'(1)
                                                             : ID_BITS'(in_count);
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                mk_first_next   = mk_first_c;
                mk_end_next     = mk_end_c;
                res_first_next  = '0;
                res_end_next    = '0;
                res_status_next = STATUS_OK;
                scan_next       = '0;
                if (is_alloc) begin
                    if (fcnt_reg == '0) begin
                        res_first_next = mk_first_c;
                        res_end_next   = mk_end_c;
                        hw_next        = hw_plus_cnt;
                        state_next     = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end else if (rb_reg == re_reg) begin
                    state_next = ST_DONE;
                end else if ((re_reg - ID_BITS'(1)) == hw_reg) begin
                    // range touches the top: pull the mark down
                    hw_next    = rb_reg - ID_BITS'(1);
                    state_next = ST_DONE;
                end else if (fcnt_reg == '0) begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = {rb_reg, re_reg};
                    fcnt_next  = CNT_W'(1);
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // reads run one entry ahead of the compare
                if (scan_issue) begin
                    ram_raddr   = scan_reg[IDX_W-1:0];
                    ev_idx_next = scan_reg[IDX_W-1:0];
                    scan_next   = scan_reg + CNT_W'(1);
                end
                if (ev_vld_reg) begin
                    if (is_alloc) begin
                        if (alloc_hit) begin
                            leave_scan     = 1'b1;
                            res_first_next = rd_b;
                            res_end_next   = nb;
                            if (nb == rd_e) begin
                                sh_rd_next = CNT_W'(ev_idx_reg) + CNT_W'(1);
                                state_next = ST_SHIFT;
                            end else begin
                                ram_we     = 1'b1;
                                ram_wdata  = {nb, rd_e};
                                state_next = ST_DONE;
                            end
                        end else if (last_ev) begin
                            leave_scan     = 1'b1;
                            res_first_next = mk_first_reg;
                            res_end_next   = mk_end_reg;
                            hw_next        = hw_plus_cnt;
                            state_next     = ST_DONE;
                        end
                    end else begin
                        if (end_hit) begin
                            leave_scan = 1'b1;
                            ram_we     = 1'b1;
                            ram_wdata  = {rd_b, re_reg};
                            state_next = ST_DONE;
                        end else if (beg_hit) begin
                            leave_scan = 1'b1;
                            ram_we     = 1'b1;
                            ram_wdata  = {rb_reg, rd_e};
                            state_next = ST_DONE;
                        end else if (last_ev) begin
                            leave_scan = 1'b1;
                            state_next = ST_DONE;
                            if (list_full) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = fcnt_reg[IDX_W-1:0];
                                ram_wdata = {rb_reg, re_reg};
                                fcnt_next = fcnt_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                ev_vld_next = scan_issue && !leave_scan;
            end

            ST_SHIFT: begin
                // move entry j+1 down to j, read and write overlapped
                if (sh_issue) begin
                    ram_raddr   = sh_rd_reg[IDX_W-1:0];
                    sh_vld_next = 1'b1;
                    sh_rd_next  = sh_rd_reg + CNT_W'(1);
                    sh_wr_next  = IDX_W'(sh_rd_reg - CNT_W'(1));
                end
                if (sh_vld_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = sh_wr_reg;
                    ram_wdata = ram_rdata;
                end
                if (!sh_issue && !sh_vld_reg) begin
                    fcnt_next  = fcnt_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_first  = res_first_reg;
    assign res_end    = res_end_reg;
    assign res_status = res_status_reg;

    a_fcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= CNT_W'(FREE_SLOTS))
        else $error("free list count above capacity");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res_status_reg == STATUS_FULL)) |-> (list_full && !is_alloc))
        else $error("full status without a full list on a release");

    a_scan_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_vld_reg |-> (CNT_W'(ev_idx_reg) < fcnt_reg))
        else $error("scan compare outside the live list");

    a_shift_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SHIFT) && ram_we) |-> ((CNT_W'(sh_wr_reg) + CNT_W'(1)) < fcnt_reg))
        else $error("gap close writes past the list end");

    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted request not decoded");

endmodule

/* hw/rtl/entity_id_range_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_id_range_allocator: first-fit ID range allocator
// Steps: the core decodes a request, scans the free list through the store
//   when the list holds entries and the request needs it, and removes a
//   drained range by moving each later entry down (store read port).
// One request at a time.
// Reset: synchronous, active low; mark and list count clear, store unset.
// ----------------------------------------------------------------------------
module entity_id_range_allocator #(
    parameter int FREE_SLOTS = eira_pkg::FREE_SLOTS_DEF,
    parameter int ID_BITS    = eira_pkg::ID_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // request channel
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata, low bit up: first_id, end_id, count, zero pad
    input  logic [((2*ID_BITS + eira_pkg::COUNT_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: kind
    input  logic [1:0] s_axis_tuser,
    // result channel
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata, low bit up: alloc_first, alloc_end, zero pad
    output logic [((2*ID_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: status
    output logic [0:0] m_axis_tuser
);

    import eira_pkg::*;

    localparam int IDX_W    = $clog2(FREE_SLOTS);
    localparam int M_DATA_W = ((2*ID_BITS + 7) / 8) * 8;

    // core <-> range store
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [2*ID_BITS-1:0] ram_wdata, ram_rdata;

    // core result
    logic               res_valid, res_ready, res_status;
    logic [ID_BITS-1:0] res_first, res_end;

    // output register: the core may take the next request while a result
    // waits here for the downstream side
    logic               m_valid_reg, m_valid_next;
    logic [ID_BITS-1:0] m_first_reg, m_end_reg;
    logic               m_status_reg;

    eira_ram #(
        .DEPTH (FREE_SLOTS),
        .WIDTH (2*ID_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    eira_core #(
        .FREE_SLOTS (FREE_SLOTS),
        .ID_BITS    (ID_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_kind     (kind_t'(s_axis_tuser)),
        .in_first_id (s_axis_tdata[ID_BITS-1:0]),
        .in_end_id   (s_axis_tdata[2*ID_BITS-1:ID_BITS]),
        .in_count    (s_axis_tdata[2*ID_BITS +: COUNT_BITS]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_first   (res_first),
        .res_end     (res_end),
        .res_status  (res_status),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // free slot in the output register, or it empties this cycle
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_first_reg  <= res_first;
            m_end_reg    <= res_end;
            m_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DATA_W'({m_end_reg, m_first_reg});
    assign m_axis_tuser  = m_status_reg;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |=> (m_valid_reg && $stable(m_first_reg)
                                             && $stable(m_end_reg)))
        else $error("pending result changed before transfer");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |-> (!m_valid_reg || m_axis_tready))
        else $error("result loaded over a pending one");

    a_status_zero_ids: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == STATUS_FULL)) |->
            ((m_first_reg == '0) && (m_end_reg == '0)))
        else $error("dropped release reports identifiers");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for entity_id_range_allocator
// Runs a directed table, then about 500 random requests that allocate IDs,
// release IDs the bench holds, move the mark and inject stray releases. A
// predictor models the mark and the free list. Each result transfer is
// compared with the oldest predicted grant. Both channels idle at random,
// except during one stretch with no idling.
// ----------------------------------------------------------------------------
module testbench;
    import eira_pkg::*;

    localparam int SLOTS      = FREE_SLOTS_DEF;
    localparam int RAND_ITEMS = 500;
    localparam int LIMIT      = 300000;   // cycles before the run is abandoned
    localparam int DRAIN      = 60;       // settle time after the last grant

    // one result transfer: granted range and status
    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        full;
    } grant_t;

    // directed table row; reps > 1 repeats the row with first_id stepped by 2
    typedef struct {
        kind_t       kind;
        logic [31:0] fid;
        logic [31:0] eid;
        logic [15:0] cnt;
        int          reps;
        bit          typed;     // expected grant given in the row itself
        grant_t      fixed;
    } dir_row_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;    // first_id, end_id, count
    logic [1:0]  s_axis_tuser  = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // alloc_first, alloc_end
    logic [0:0]  m_axis_tuser;          // status

    // predictor state: high-water mark and the ordered free list
    logic [31:0] mark;
    logic [31:0] gap_lo [SLOTS];
    logic [31:0] gap_hi [SLOTS];
    int          gap_cnt;

    grant_t   grant_q [$];      // predicted grants, oldest first
    grant_t   held_q [$];       // ranges currently handed out to the bench
    dir_row_t plan_q [$];
    int       miss_count = 0;
    int       cycles     = 0;
    bit       steady     = 1'b0; // no idling on either side while set

    entity_id_range_allocator u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("entity_id_range_allocator: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void drop_gap(int pos);
        int j;
        for (j = pos; j < gap_cnt - 1; j++) begin
            gap_lo[j] = gap_lo[j + 1];
            gap_hi[j] = gap_hi[j + 1];
        end
        gap_cnt--;
    endfunction

    function automatic grant_t pool_apply(kind_t k, logic [31:0] fid, logic [31:0] eid,
                                          logic [15:0] cnt);
        grant_t      g;
        logic [31:0] rb;
        logic [31:0] re;
        int          i;
        bit          hit;
        g   = '0;
        hit = 1'b0;
        case (k)
            KIND_ALLOC_ONE: begin
                if (gap_cnt == 0) begin
                    mark = mark + 32'd1;
                    g.lo = mark;
                end else begin
                    g.lo      = gap_lo[0];
                    gap_lo[0] = gap_lo[0] + 32'd1;
                    if (gap_lo[0] == gap_hi[0])
                        drop_gap(0);
                end
                g.hi = g.lo + 32'd1;
            end
            KIND_ALLOC_RANGE: begin
                // first fit; length is taken modulo the ID space
                for (i = 0; i < gap_cnt && !hit; i++) begin
                    if (gap_hi[i] - gap_lo[i] >= {16'd0, cnt}) begin
                        g.lo      = gap_lo[i];
                        g.hi      = gap_lo[i] + {16'd0, cnt};
                        gap_lo[i] = g.hi;
                        if (gap_lo[i] == gap_hi[i])
                            drop_gap(i);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    g.lo = mark + 32'd1;
                    g.hi = g.lo + {16'd0, cnt};
                    mark = mark + {16'd0, cnt};
                end
            end
            default: begin
                rb = fid;
                re = (k == KIND_REL_ONE) ? fid + 32'd1 : eid;
                if (rb != re) begin
                    if (re - 32'd1 == mark) begin
                        mark = rb - 32'd1;
                    end else begin
                        // first range touching at its end or its front; end wins within a range
                        for (i = 0; i < gap_cnt && !hit; i++) begin
                            if (gap_hi[i] == rb) begin
                                gap_hi[i] = re;
                                hit = 1'b1;
                            end else if (gap_lo[i] == re) begin
                                gap_lo[i] = rb;
                                hit = 1'b1;
                            end
                        end
                        if (!hit) begin
                            if (gap_cnt < SLOTS) begin
                                gap_lo[gap_cnt] = rb;
                                gap_hi[gap_cnt] = re;
                                gap_cnt++;
                            end else begin
                                g.full = STATUS_FULL;
                            end
                        end
                    end
                end
            end
        endcase
        return g;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // Presents one request, waits for its transfer, then books the grant.
    // tvalid stays high across back-to-back requests.
    task automatic issue(input kind_t k, input logic [31:0] fid, input logic [31:0] eid,
                         input logic [15:0] cnt, input bit typed, input grant_t fixed,
                         output grant_t got);
        grant_t g;
        while (!steady && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cnt, eid, fid};
        s_axis_tuser  <= k;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        g = pool_apply(k, fid, eid, cnt);
        grant_q.push_back(typed ? fixed : g);
        got = g;
    endtask

    function automatic dir_row_t row(kind_t k, logic [31:0] fid, logic [31:0] eid,
                                     logic [15:0] cnt, int reps, bit typed,
                                     logic [31:0] xlo, logic [31:0] xhi, logic xfull);
        dir_row_t r;
        r.kind  = k;
        r.fid   = fid;
        r.eid   = eid;
        r.cnt   = cnt;
        r.reps  = reps;
        r.typed = typed;
        r.fixed = '{lo: xlo, hi: xhi, full: xfull};
        return r;
    endfunction

    initial begin
        grant_t      g;
        kind_t       k;
        logic [31:0] fid;
        logic [31:0] eid;
        logic [15:0] cnt;
        int          sel;
        int          idx;
        int          n;
        int          rep;

        mark    = '0;
        gap_cnt = 0;
        foreach (gap_lo[i]) begin
            gap_lo[i] = '0;
            gap_hi[i] = '0;
        end

        // Directed table, starting from reset: mark 0, free list empty.
        // Unused fields in the early rows carry all-ones to show they are ignored.
        plan_q.push_back(row(KIND_ALLOC_ONE, '1, '1, 16'hFFFF, 1, 1, 32'd1, 32'd2, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_RANGE, '1, '1, 16'hFFFF, 1, 1,
                             32'd2, 32'h10001, STATUS_OK));
        // release 5, then 4 grows its front, then 6 grows its end: [4,7)
        plan_q.push_back(row(KIND_REL_ONE, 32'd5, '1, '1, 1, 1, '0, '0, STATUS_OK));
        plan_q.push_back(row(KIND_REL_ONE, 32'd4, '1, '1, 1, 1, '0, '0, STATUS_OK));
        plan_q.push_back(row(KIND_REL_ONE, 32'd6, '1, '1, 1, 1, '0, '0, STATUS_OK));
        // range touching the mark lowers it to 0xFFEF
        plan_q.push_back(row(KIND_REL_RANGE, 32'hFFF0, 32'h10001, '1, 1, 1,
                             '0, '0, STATUS_OK));
        // empty release range: no change
        plan_q.push_back(row(KIND_REL_RANGE, 32'd9, 32'd9, '1, 1, 1, '0, '0, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_ONE, '0, '0, '0, 1, 1, 32'd4, 32'd5, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_RANGE, '0, '0, 16'd1, 1, 1,
                             32'd5, 32'd6, STATUS_OK));
        // front range too short: falls back to the mark
        plan_q.push_back(row(KIND_ALLOC_RANGE, '0, '0, 16'd2, 1, 1,
                             32'hFFF0, 32'hFFF2, STATUS_OK));
        // zero count yields an empty range from the front entry
        plan_q.push_back(row(KIND_ALLOC_RANGE, '0, '0, 16'd0, 1, 1,
                             32'd6, 32'd6, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_ONE, '0, '0, '0, 1, 1, 32'd6, 32'd7, STATUS_OK));
        // reversed range wraps through zero, then is handed out whole
        plan_q.push_back(row(KIND_REL_RANGE, 32'hFFFFFFF0, 32'h10, '0, 1, 1,
                             '0, '0, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_RANGE, '0, '0, 16'h20, 1, 1,
                             32'hFFFFFFF0, 32'h10, STATUS_OK));
        // pull the mark near the top, then wrap it past zero
        plan_q.push_back(row(KIND_REL_RANGE, 32'hFFFFFFF0, 32'hFFF2, '0, 1, 1,
                             '0, '0, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_RANGE, '0, '0, 16'h20, 1, 1,
                             32'hFFFFFFF0, 32'h10, STATUS_OK));
        // sixteen isolated releases fill the list; checked by the predictor
        plan_q.push_back(row(KIND_REL_ONE, 32'h1000, '0, '0, SLOTS, 0, '0, '0, STATUS_OK));
        // list full: appends are dropped
        plan_q.push_back(row(KIND_REL_ONE, 32'h2000, '0, '0, 1, 1, '0, '0, STATUS_FULL));
        plan_q.push_back(row(KIND_REL_ONE, 32'hFFFFFFFF, '0, '0, 1, 1,
                             '0, '0, STATUS_FULL));
        // adjacent release still lands in a full list
        plan_q.push_back(row(KIND_REL_RANGE, 32'h1001, 32'h1002, '0, 1, 1,
                             '0, '0, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_RANGE, '0, '0, 16'hFFFF, 1, 0, '0, '0, STATUS_OK));
        // release one at the mark decrements it
        plan_q.push_back(row(KIND_REL_ONE, 32'h1000E, '0, '0, 1, 1, '0, '0, STATUS_OK));
        plan_q.push_back(row(KIND_ALLOC_ONE, '0, '0, '0, 1, 0, '0, '0, STATUS_OK));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan_q[p]) begin
            for (rep = 0; rep < plan_q[p].reps; rep++)
                issue(plan_q[p].kind, plan_q[p].fid + 32'd2 * rep, plan_q[p].eid,
                      plan_q[p].cnt, plan_q[p].typed, plan_q[p].fixed, g);
        end

        // Random part: mostly allocations and releases of held ranges, so the
        // list keeps filling, extending and draining; the rest moves the mark
        // or releases arbitrary IDs.
        for (n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 200 && n < 330);
            fid = $urandom;
            eid = $urandom;
            cnt = 16'($urandom_range(16'hFFFF));
            sel = $urandom_range(99);
            if (held_q.size() > 48)
                sel = 50;
            if (sel < 28) begin
                k = KIND_ALLOC_ONE;
            end else if (sel < 48) begin
                k   = KIND_ALLOC_RANGE;
                cnt = ($urandom_range(19) == 0) ? 16'($urandom_range(16'hFFFF, 1))
                                                : 16'($urandom_range(8, 1));
            end else if (sel < 78 && held_q.size() > 0) begin
                idx = $urandom_range(held_q.size() - 1);
                g   = held_q[idx];
                held_q.delete(idx);
                fid = g.lo;
                if (g.hi - g.lo == 32'd1) begin
                    k = KIND_REL_ONE;
                end else if ($urandom_range(1) == 0) begin
                    k   = KIND_REL_RANGE;
                    eid = g.hi;
                end else begin
                    // give back the first ID, keep the rest
                    k = KIND_REL_ONE;
                    held_q.push_back('{lo: g.lo + 32'd1, hi: g.hi, full: 1'b0});
                end
            end else if (sel < 81) begin
                // range ending at the mark moves it anywhere, wrap included
                k   = KIND_REL_RANGE;
                eid = mark + 32'd1;
            end else begin
                k = ($urandom_range(1) == 0) ? KIND_REL_ONE : KIND_REL_RANGE;
                if ($urandom_range(1) == 0)
                    eid = fid + $urandom_range(16, 1);
            end
            issue(k, fid, eid, cnt, 1'b0, '0, g);
            if ((k == KIND_ALLOC_ONE || k == KIND_ALLOC_RANGE) && g.lo != g.hi)
                held_q.push_back(g);
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (grant_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (miss_count == 0) begin
            $display("entity_id_range_allocator: match");
        end else begin
            $display("entity_id_range_allocator: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 7);
    end

    task automatic note_miss(input string what, input logic [31:0] got,
                             input logic [31:0] want);
        $display("%0t ns: %s got %h, predicted %h", $time, what, got, want);
        miss_count++;
    endtask

    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (grant_q.size() == 0) begin
                note_miss("result with no request pending", m_axis_tdata[31:0], '0);
            end else begin
                want = grant_q.pop_front();
                if (m_axis_tdata[31:0] !== want.lo)
                    note_miss("alloc_first", m_axis_tdata[31:0], want.lo);
                if (m_axis_tdata[63:32] !== want.hi)
                    note_miss("alloc_end", m_axis_tdata[63:32], want.hi);
                if (m_axis_tuser[0] !== want.full)
                    note_miss("status", {31'd0, m_axis_tuser[0]}, {31'd0, want.full});
            end
        end
    end

endmodule
